// File: rtl/core/rmts_pkg.sv
package rmts_pkg;

  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned TIME_BITS = 16;

  localparam int unsigned IDX_W  = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int unsigned NUM_W  = 5;
  localparam int unsigned ACT_W  = (CNT_W > NUM_W) ? CNT_W : NUM_W;
  localparam int unsigned TIDX_W = 4;
  localparam int unsigned WORK_W = 16;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned CMP_W  = (TIME_BITS > PER_W) ? TIME_BITS : PER_W;

  localparam logic [NUM_W-1:0] NUM_TASKS_RESET = NUM_W'(3);

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_TICK  = 1'b1
  } rmts_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIX
  } rmts_state_e;

  typedef struct packed {
    logic [WORK_W-1:0]    work;
    logic [PER_W-1:0]     period;
    logic [WORK_W-1:0]    rem;
    logic [TIME_BITS-1:0] phase;
  } task_row_t;

  localparam int unsigned ROW_W = $bits(task_row_t);

  localparam task_row_t ROW_RESET = '{
    work:   '0,
    period: PER_W'(1),
    rem:    '0,
    phase:  '0
  };

endpackage

// File: rtl/core/rmts_req_if.sv
interface rmts_req_if;
  import rmts_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [TIDX_W-1:0]   task_index;
  logic [WORK_W-1:0]   work_amount;
  logic [PER_W-1:0]    task_period;

  modport source (output valid, output func, output task_index, output work_amount,
                  output task_period, input ready);
  modport sink   (input valid, input func, input task_index, input work_amount,
                  input task_period, output ready);
endinterface

// File: rtl/core/rmts_rsp_if.sv
interface rmts_rsp_if;
  import rmts_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIDX_W-1:0] running_task;
  logic              idle;

  modport source (output valid, output running_task, output idle, input ready);
  modport sink   (input valid, input running_task, input idle, output ready);
endinterface

// File: rtl/core/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler over a table of periodic tasks.
// req_i (valid/ready) carries one request: func selects a table write or a tick.
// A write request stores work and period for task_index (period 0 stored as 1),
// reloads the remaining work and clears the phase, and gives no result.
// A tick request walks the active entries (min(num_tasks, table size)), one
// entry per cycle through the single table memory port, picking the ready task
// with the shortest period and releasing tasks whose period has elapsed. A
// tick runs from acceptance through the scan and the final step to its result
// on rsp_o; req_i is not ready during that walk.
// rsp_o holds running_task and idle in an output register until taken; a
// stalled receiver holds only the final step of the next tick.
// cfg_we_i/cfg_wdata_i write num_tasks; the user must write only while the block is idle (not enforced).
// Reset clears the table to work 0, period 1, remaining 0, phase 0 through
// per-entry valid bits, sets num_tasks to 3 and leaves no result pending;
// the block is ready as soon as reset is released.
module rate_monotonic_tick_scheduler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rmts_pkg::NUM_W-1:0] cfg_wdata_i,
  rmts_req_if.sink                   req_i,
  rmts_rsp_if.source                 rsp_o
);
  import rmts_pkg::*;

  rmts_state_e           state_q, state_d;
  logic [NUM_W-1:0]      num_tasks_q;
  logic [MAX_TASKS-1:0]  valid_q, valid_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [PER_W-1:0]      best_per_q, best_per_d;
  logic                  best_rel_q, best_rel_d;
  task_row_t             best_row_q, best_row_d;
  logic                  rsp_vld_q, rsp_vld_d;
  logic [TIDX_W-1:0]     rsp_task_q, rsp_task_d;
  logic                  rsp_idle_q, rsp_idle_d;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  task_row_t             ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ROW_W-1:0]      ram_rdata;

  task_row_t             row_rd;
  task_row_t             row_upd;
  logic [TIME_BITS-1:0]  ph_next;
  logic                  rel;
  logic                  better;
  logic [ACT_W-1:0]      act_ext;
  logic [CNT_W-1:0]      act_n;
  logic                  accept;
  logic                  last_entry;

  rmts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready        = (state_q == ST_IDLE);
  assign accept             = req_i.valid && req_i.ready;
  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.running_task = rsp_task_q;
  assign rsp_o.idle         = rsp_idle_q;

  assign act_ext = (ACT_W'(num_tasks_q) > ACT_W'(MAX_TASKS)) ? ACT_W'(MAX_TASKS)
                                                              : ACT_W'(num_tasks_q);
  assign act_n   = CNT_W'(act_ext);

  assign row_rd     = valid_q[cnt_q] ? task_row_t'(ram_rdata) : ROW_RESET;
  assign ph_next    = TIME_BITS'(row_rd.phase + TIME_BITS'(1));
  assign rel        = (ph_next == '0) || (CMP_W'(ph_next) >= CMP_W'(row_rd.period));
  assign better     = (row_rd.rem != '0) && (!found_q || (row_rd.period < best_per_q));
  assign last_entry = ((CNT_W'(cnt_q) + CNT_W'(1)) == n_q);

  always_comb begin
    row_upd = row_rd;
    if (rel) begin
      row_upd.phase = '0;
      row_upd.rem   = row_rd.work;
    end else begin
      row_upd.phase = ph_next;
    end
  end

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_per_d = best_per_q;
    best_rel_d = best_rel_q;
    best_row_d = best_row_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    rsp_task_d = rsp_task_q;
    rsp_idle_d = rsp_idle_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q;
    ram_wdata  = row_upd;
    ram_raddr  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.func == FUNC_WRITE) begin
            if (32'(req_i.task_index) < 32'(MAX_TASKS)) begin
              ram_we           = 1'b1;
              ram_waddr        = IDX_W'(req_i.task_index);
              ram_wdata.work   = req_i.work_amount;
              ram_wdata.period = (req_i.task_period == '0) ? PER_W'(1) : req_i.task_period;
              ram_wdata.rem    = req_i.work_amount;
              ram_wdata.phase  = '0;
              valid_d[IDX_W'(req_i.task_index)] = 1'b1;
            end
          end else begin
            found_d    = 1'b0;
            best_rel_d = 1'b0;
            n_d        = act_n;
            cnt_d      = '0;
            state_d    = (act_n == '0) ? ST_FIX : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr        = IDX_W'(cnt_q + IDX_W'(1));
        ram_we           = 1'b1;
        valid_d[cnt_q]   = 1'b1;
        if (better) begin
          found_d        = 1'b1;
          best_idx_d     = cnt_q;
          best_per_d     = row_rd.period;
          best_rel_d     = rel;
          best_row_d     = row_upd;
          best_row_d.rem = WORK_W'(row_rd.rem - WORK_W'(1));
        end
        if (last_entry) begin
          state_d = ST_FIX;
        end else begin
          cnt_d = IDX_W'(cnt_q + IDX_W'(1));
        end
      end
      ST_FIX: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          ram_we     = found_q && !best_rel_q;
          ram_waddr  = best_idx_q;
          ram_wdata  = best_row_q;
          rsp_vld_d  = 1'b1;
          rsp_task_d = found_q ? TIDX_W'(best_idx_q) : '0;
          rsp_idle_d = !found_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_tasks_q <= NUM_TASKS_RESET;
      valid_q     <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      found_q     <= 1'b0;
      best_rel_q  <= 1'b0;
      rsp_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      cnt_q      <= cnt_d;
      n_q        <= n_d;
      found_q    <= found_d;
      best_rel_q <= best_rel_d;
      rsp_vld_q  <= rsp_vld_d;
      if (cfg_we_i) begin
        num_tasks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_per_q <= best_per_d;
    best_row_q <= best_row_d;
    rsp_task_q <= rsp_task_d;
    rsp_idle_q <= rsp_idle_d;
  end

  a_rsp_from_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == ST_FIX))
    else $error("result raised outside the final step");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(cnt_q) < n_q))
    else $error("scan index beyond active entries");

  a_idle_task_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.idle) |-> (rsp_o.running_task == '0))
    else $error("idle result with a task index");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> (state_q == ST_SCAN || state_q == ST_FIX))
    else $error("scan left without the final step");

endmodule

// File: rtl/core/rmts_ram.sv
module rmts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
